/* hdl/lie_pkg.sv */
// shared types and constants for the line input editor with echo
// used by every module of the block; depends on nothing
`default_nettype none

package lie_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int INDEX_W = 8;
   localparam int LEN_W = 9;

   // longest line the store can hold
   localparam int MAX_LINE = 256;

   // programmed limit saturates here
   localparam logic [LEN_W-1:0] LIMIT_CAP =
      (MAX_LINE > 511) ? 9'd511 : LEN_W'(MAX_LINE);

   // line limit after reset
   localparam logic [LEN_W-1:0] LIMIT_RESET = 9'd10;

   // character codes
   localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
   localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
   localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
   localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

   // how one received byte is handled
   localparam logic [2:0] K_EOT       = 3'd0;  // end of line, no echo
   localparam logic [2:0] K_NOP       = 3'd1;  // erase at start of line
   localparam logic [2:0] K_ERASE     = 3'd2;  // backspace, space, backspace
   localparam logic [2:0] K_EOL       = 3'd3;  // cr or lf, echo lf
   localparam logic [2:0] K_CHAR      = 3'd4;  // plain echo
   localparam logic [2:0] K_CHAR_FULL = 3'd5;  // plain echo, then lf, line full

   // decoded item handed to the result sequencer
   typedef struct packed {
      logic [2:0]         kind;
      logic [BYTE_W-1:0]  rx_byte;
      logic [INDEX_W-1:0] index;
      logic [LEN_W-1:0]   length;
   } rec_type;

endpackage

`default_nettype wire

/* hdl/lie_decode.sv */
// classifies one received byte against the current line position
// depends on lie_pkg
`default_nettype none

module lie_decode #(
   parameter int MAX_LINE = lie_pkg::MAX_LINE
) (
   input  wire logic [lie_pkg::BYTE_W-1:0] rx_byte,
   input  wire logic [lie_pkg::LEN_W-1:0]  char_count,
   input  wire logic [lie_pkg::LEN_W-1:0]  line_limit,
   output lie_pkg::rec_type                rec,
   output logic      [lie_pkg::LEN_W-1:0]  count_next
);

   // programmed limit saturates at the line size, or at the largest limit value
   localparam int CAP_VAL = (MAX_LINE > (1 << lie_pkg::LEN_W) - 1) ?
                            (1 << lie_pkg::LEN_W) - 1 : MAX_LINE;
   localparam logic [lie_pkg::LEN_W-1:0] LIMIT_CAP = CAP_VAL[lie_pkg::LEN_W-1:0];

   logic [lie_pkg::LEN_W-1:0] lim;
   logic [lie_pkg::LEN_W-1:0] nc;
   logic                      full;

   // effective limit and next position
   assign lim  = (line_limit > LIMIT_CAP) ? LIMIT_CAP : line_limit;
   assign nc   = char_count + 9'd1;
   assign full = (nc >= lim);

   // kind, stored fields and position update
   always_comb begin
      rec.rx_byte = rx_byte;
      rec.index   = char_count[lie_pkg::INDEX_W-1:0];
      rec.length  = '0;
      rec.kind    = lie_pkg::K_CHAR;
      count_next  = char_count;
      if (rx_byte == lie_pkg::CH_EOT) begin
         rec.kind   = lie_pkg::K_EOT;
         rec.length = char_count;
         count_next = '0;
      end else if (rx_byte == lie_pkg::CH_DEL) begin
         if (char_count != '0) begin
            rec.kind   = lie_pkg::K_ERASE;
            count_next = char_count - 9'd1;
         end else begin
            rec.kind = lie_pkg::K_NOP;
         end
      end else if (rx_byte == lie_pkg::CH_LF || rx_byte == lie_pkg::CH_CR) begin
         rec.kind   = lie_pkg::K_EOL;
         rec.length = nc;
         count_next = '0;
      end else if (full) begin
         rec.kind   = lie_pkg::K_CHAR_FULL;
         rec.length = nc;
         count_next = '0;
      end else begin
         rec.kind   = lie_pkg::K_CHAR;
         count_next = nc;
      end
   end

endmodule

`default_nettype wire

/* hdl/lie_seq.sv */
// holds one decoded item and emits its one to three results into the
// output register; depends on lie_pkg
`default_nettype none

module lie_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          item_valid,
   input  wire lie_pkg::rec_type              item_rec,
   output logic                               item_take,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_echo_valid,
   output logic [lie_pkg::BYTE_W-1:0]         rsp_echo_byte,
   output logic                               rsp_store_valid,
   output logic [lie_pkg::INDEX_W-1:0]        rsp_store_index,
   output logic [lie_pkg::BYTE_W-1:0]         rsp_store_byte,
   output logic                               rsp_line_done,
   output logic [lie_pkg::LEN_W-1:0]          rsp_line_length,
   output logic                               rsp_last
);

   lie_pkg::rec_type rec_ff;
   logic       busy_ff, busy_in;
   logic [1:0] step_ff, step_in;

   logic                         out_vld_ff, out_vld_in;
   logic                         echo_v_ff, echo_v_in;
   logic [lie_pkg::BYTE_W-1:0]   echo_b_ff, echo_b_in;
   logic                         store_v_ff, store_v_in;
   logic [lie_pkg::INDEX_W-1:0]  store_i_ff, store_i_in;
   logic [lie_pkg::BYTE_W-1:0]   store_b_ff, store_b_in;
   logic                         done_ff, done_in;
   logic [lie_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                         last_ff, last_in;

   logic       out_take;
   logic       fire;
   logic       finish;
   logic [1:0] last_step;

   // handshake between item slot and output register
   assign out_take  = !out_vld_ff || !rsp_stall;
   assign fire      = busy_ff && out_take;
   assign finish    = fire && (step_ff == last_step);
   assign item_take = item_valid && (!busy_ff || finish);

   // result of the current step
   always_comb begin
      echo_v_in = 1'b0;
      echo_b_in = '0;
      done_in   = 1'b0;
      last_step = 2'd0;
      case (rec_ff.kind)
         lie_pkg::K_EOT: begin
            done_in = 1'b1;
         end
         lie_pkg::K_NOP: begin
            done_in = 1'b0;
         end
         lie_pkg::K_ERASE: begin
            last_step = 2'd2;
            echo_v_in = 1'b1;
            echo_b_in = (step_ff == 2'd1) ? lie_pkg::CH_SP : lie_pkg::CH_BS;
         end
         lie_pkg::K_EOL: begin
            echo_v_in = 1'b1;
            echo_b_in = lie_pkg::CH_LF;
            done_in   = 1'b1;
         end
         lie_pkg::K_CHAR: begin
            echo_v_in = 1'b1;
            echo_b_in = rec_ff.rx_byte;
         end
         lie_pkg::K_CHAR_FULL: begin
            last_step = 2'd1;
            echo_v_in = 1'b1;
            if (step_ff == 2'd0) begin
               echo_b_in = rec_ff.rx_byte;
            end else begin
               echo_b_in = lie_pkg::CH_LF;
               done_in   = 1'b1;
            end
         end
         default: begin
            echo_v_in = 1'b0;
         end
      endcase
      store_v_in = (step_ff == 2'd0);
      store_i_in = store_v_in ? rec_ff.index : '0;
      store_b_in = store_v_in ? rec_ff.rx_byte : '0;
      len_in     = done_in ? rec_ff.length : '0;
      last_in    = (step_ff == last_step);
   end

   // item slot and step counter
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (item_take) begin
         busy_in = 1'b1;
         step_in = 2'd0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (fire) begin
         step_in = step_ff + 2'd1;
      end
   end

   assign out_vld_in = out_take ? busy_ff : out_vld_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         step_ff    <= 2'd0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         step_ff    <= step_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (item_take) begin
         rec_ff <= item_rec;
      end
      if (out_take) begin
         echo_v_ff  <= echo_v_in;
         echo_b_ff  <= echo_b_in;
         store_v_ff <= store_v_in;
         store_i_ff <= store_i_in;
         store_b_ff <= store_b_in;
         done_ff    <= done_in;
         len_ff     <= len_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_echo_valid  = echo_v_ff;
   assign rsp_echo_byte   = echo_b_ff;
   assign rsp_store_valid = store_v_ff;
   assign rsp_store_index = store_i_ff;
   assign rsp_store_byte  = store_b_ff;
   assign rsp_line_done   = done_ff;
   assign rsp_line_length = len_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

/* hdl/line_input_editor_with_echo.sv */
// A byte's first result passes the input register, item slot and output register
// to rsp_valid. Throughput: one result per cycle from the output register while
// rsp_stall is low; a byte gives one result, two if it fills the line, three for
// an erase (backspace, space, backspace); lie_seq's step counter sets the rate.
// Reset (synchronous): empties every stage, position to 0, line limit to 10.
// top level: input register, line position, limit register, decode, sequencer
// depends on lie_pkg, lie_decode and lie_seq
`default_nettype none

module line_input_editor_with_echo #(
   parameter int MAX_LINE = lie_pkg::MAX_LINE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [lie_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_echo_valid,
   output logic [lie_pkg::BYTE_W-1:0]         rsp_echo_byte,
   output logic                               rsp_store_valid,
   output logic [lie_pkg::INDEX_W-1:0]        rsp_store_index,
   output logic [lie_pkg::BYTE_W-1:0]         rsp_store_byte,
   output logic                               rsp_line_done,
   output logic [lie_pkg::LEN_W-1:0]          rsp_line_length,
   output logic                               rsp_last,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [lie_pkg::LEN_W-1:0]     csr_line_limit
);

   logic                        in_vld_ff, in_vld_in;
   logic [lie_pkg::BYTE_W-1:0]  in_byte_ff;
   logic [lie_pkg::LEN_W-1:0]   count_ff, count_in;
   logic [lie_pkg::LEN_W-1:0]   limit_ff, limit_in;

   lie_pkg::rec_type            rec;
   logic [lie_pkg::LEN_W-1:0]   count_next;
   logic                        item_take;
   logic                        req_xfer;

   // input register handshake
   assign req_stall = in_vld_ff && !item_take;
   assign req_xfer  = req_valid && !req_stall;
   assign in_vld_in = req_xfer ? 1'b1 : (item_take ? 1'b0 : in_vld_ff);

   // line position is updated when the sequencer takes the item
   assign count_in = item_take ? count_next : count_ff;

   // limit register, always writable
   assign csr_ready = 1'b1;
   assign limit_in  = (csr_valid && csr_ready) ? csr_line_limit : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         count_ff  <= '0;
         limit_ff  <= lie_pkg::LIMIT_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         count_ff  <= count_in;
         limit_ff  <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // byte classification
   lie_decode #(
      .MAX_LINE (MAX_LINE)
   ) u_decode (
      .rx_byte    (in_byte_ff),
      .char_count (count_ff),
      .line_limit (limit_ff),
      .rec        (rec),
      .count_next (count_next)
   );

   // result sequencing and output register
   lie_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (in_vld_ff),
      .item_rec        (rec),
      .item_take       (item_take),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_echo_valid  (rsp_echo_valid),
      .rsp_echo_byte   (rsp_echo_byte),
      .rsp_store_valid (rsp_store_valid),
      .rsp_store_index (rsp_store_index),
      .rsp_store_byte  (rsp_store_byte),
      .rsp_line_done   (rsp_line_done),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

/* hdl/lie_checker.sv */
// port-level checks for the line input editor, bound to the top level
// depends on lie_pkg and line_input_editor_with_echo
`default_nettype none

module lie_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic                          rsp_echo_valid,
   input wire logic [lie_pkg::BYTE_W-1:0]    rsp_echo_byte,
   input wire logic                          rsp_store_valid,
   input wire logic [lie_pkg::INDEX_W-1:0]   rsp_store_index,
   input wire logic                          rsp_line_done,
   input wire logic [lie_pkg::LEN_W-1:0]     rsp_line_length,
   input wire logic                          rsp_last
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_echo_byte)
         && $stable(rsp_last) && $stable(rsp_line_length))
      else $error("stalled result changed");

   // a finished line is always the final result of its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done |-> rsp_last)
      else $error("line done on a non-final result");

   // length and echo byte are zero when unused
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_done || rsp_line_length == '0)
         && (rsp_echo_valid || rsp_echo_byte == '0))
      else $error("unused field not zero");

   // store index is zero when no store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_store_valid |-> rsp_store_index == '0)
      else $error("store index set without store");

endmodule

bind line_input_editor_with_echo lie_checker u_lie_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_echo_valid  (rsp_echo_valid),
   .rsp_echo_byte   (rsp_echo_byte),
   .rsp_store_valid (rsp_store_valid),
   .rsp_store_index (rsp_store_index),
   .rsp_line_done   (rsp_line_done),
   .rsp_line_length (rsp_line_length),
   .rsp_last        (rsp_last)
);

`default_nettype wire
